// ===== design/mia_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command/status structs and a helper for the max island area block.
// No dependencies; used by the controller, the datapath and the top level.

package mia_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int AREA_W    = 13;
    localparam int AREA_MAX  = 8191;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam int ROW_RESET = 64;
    localparam int COL_RESET = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clr;
        logic load;
        logic scan_init;
        logic scan;
        logic pop;
        logic nb;
        logic nb_chk;
        logic region_end;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic scan_hit;
        logic scan_done;
        logic sp_zero;
        logic dir_last;
        logic out_busy;
    } t_stat;

    // Effective image dimension: zero acts as one, large values saturate.
    function automatic int clamp_dim(input logic [CFG_W-1:0] value, input int limit);
        int v;
        v = int'(value);
        if (v < 1) begin
            return 1;
        end
        if (v > limit) begin
            return limit;
        end
        return v;
    endfunction

endpackage

// ===== design/mia_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module mia_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mia_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: clear pass, frame load, scan and flood fill sequencing.
// Depends on mia_pkg for the command and status structs.

module mia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  mia_pkg::t_stat i_stat,
    output mia_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_NB    = 3'd4;
    localparam logic [2:0] S_LAST  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_POP;
                end else if (i_stat.scan_done && !i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            S_POP: begin
                if (i_stat.sp_zero) begin
                    o_cmd.region_end = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_NB;
                end
            end
            S_NB: begin
                o_cmd.nb = 1'b1;
                if (i_stat.dir_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.nb_chk = 1'b1;
                n_state = S_POP;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/mia_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, pixel/visited map, fill stack, counters and result register.
// Depends on mia_pkg and mia_ram.

module mia_dp #(
    parameter int MAX_ROWS = mia_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mia_pkg::MAX_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mia_pkg::t_cmd                   i_cmd,
    output mia_pkg::t_stat                  o_stat,
    input  logic                            i_pixel,
    input  logic                            i_cfg_we,
    input  logic [mia_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mia_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mia_pkg::AREA_W-1:0]      o_max_area
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS > 1 ? CELLS : 2);
    localparam int TW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
    localparam int CW    = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int SW    = RW + CW + AW;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Map entry: bit 0 is the pixel, bit 1 the visited mark.
    localparam logic [1:0] MAP_EMPTY = 2'b00;
    localparam logic [1:0] MAP_SEEN  = 2'b11;

    logic [RCW-1:0] r_rows;
    logic [CCW-1:0] r_cols;
    logic [TW-1:0]  total;

    logic [AW-1:0]  r_clr_idx;
    logic [TW-1:0]  r_load_idx;
    logic [TW-1:0]  r_scan_idx;
    logic [RW-1:0]  r_scan_r;
    logic [CW-1:0]  r_scan_c;
    logic           r_chk_v;
    logic [AW-1:0]  r_chk_pos;
    logic [RW-1:0]  r_chk_r;
    logic [CW-1:0]  r_chk_c;
    logic [TW-1:0]  r_sp;
    logic [TW-1:0]  r_area;
    logic [TW-1:0]  r_best;
    logic [1:0]     r_dir;
    logic           r_nb_v;
    logic [AW-1:0]  r_nb_pos;
    logic [RW-1:0]  r_nb_r;
    logic [CW-1:0]  r_nb_c;
    logic           r_out_valid;
    logic [mia_pkg::AREA_W-1:0] r_out_area;

    logic           map_we;
    logic [AW-1:0]  map_waddr;
    logic [1:0]     map_wdata;
    logic           map_re;
    logic [AW-1:0]  map_raddr;
    logic [1:0]     map_rdata;
    logic           stk_we;
    logic [AW-1:0]  stk_waddr;
    logic [SW-1:0]  stk_wdata;
    logic           stk_re;
    logic [AW-1:0]  stk_raddr;
    logic [SW-1:0]  stk_rdata;

    logic [RW-1:0]  cur_r;
    logic [CW-1:0]  cur_c;
    logic [AW-1:0]  cur_pos;
    logic           q_ok;
    logic [RW-1:0]  q_r;
    logic [CW-1:0]  q_c;
    logic [AW-1:0]  q_pos;

    logic           load_ok;
    logic           scan_more;
    logic           map_hit;
    logic           scan_hit;
    logic           nb_hit;
    logic           scan_wrap;

    assign total     = TW'(r_rows) * TW'(r_cols);
    assign load_ok   = r_load_idx < total;
    assign scan_more = r_scan_idx < total;
    assign map_hit   = map_rdata[0] & ~map_rdata[1];
    assign scan_hit  = r_chk_v & map_hit;
    assign nb_hit    = r_nb_v & map_hit;
    assign scan_wrap = (CCW'(r_scan_c) + CCW'(1)) == r_cols;

    assign {cur_r, cur_c, cur_pos} = stk_rdata;

    // Neighbor of the popped pixel for the current direction.
    always_comb begin
        q_ok  = 1'b0;
        q_r   = cur_r;
        q_c   = cur_c;
        q_pos = cur_pos;
        case (r_dir)
            DIR_UP: begin
                q_ok  = cur_r != '0;
                q_r   = cur_r - RW'(1);
                q_pos = cur_pos - AW'(r_cols);
            end
            DIR_LEFT: begin
                q_ok  = cur_c != '0;
                q_c   = cur_c - CW'(1);
                q_pos = cur_pos - AW'(1);
            end
            DIR_RIGHT: begin
                q_ok  = (CCW'(cur_c) + CCW'(1)) < r_cols;
                q_c   = cur_c + CW'(1);
                q_pos = cur_pos + AW'(1);
            end
            DIR_DOWN: begin
                q_ok  = (RCW'(cur_r) + RCW'(1)) < r_rows;
                q_r   = cur_r + RW'(1);
                q_pos = cur_pos + AW'(r_cols);
            end
            default: begin
                q_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_clr_idx;
        map_wdata = MAP_EMPTY;
        map_re    = 1'b0;
        map_raddr = AW'(r_scan_idx);
        stk_we    = 1'b0;
        stk_waddr = AW'(r_sp);
        stk_wdata = {r_chk_r, r_chk_c, r_chk_pos};
        stk_re    = 1'b0;
        stk_raddr = AW'(r_sp - TW'(1));

        if (i_cmd.clr) begin
            map_we = 1'b1;
        end
        if (i_cmd.load && load_ok) begin
            map_we    = 1'b1;
            map_waddr = AW'(r_load_idx);
            map_wdata = {1'b0, i_pixel};
        end
        if (i_cmd.scan) begin
            if (scan_hit) begin
                map_we    = 1'b1;
                map_waddr = r_chk_pos;
                map_wdata = MAP_SEEN;
                stk_we    = 1'b1;
                stk_waddr = '0;
            end else if (scan_more) begin
                map_re = 1'b1;
            end
        end
        if (i_cmd.pop) begin
            stk_re = 1'b1;
        end
        if ((i_cmd.nb || i_cmd.nb_chk) && nb_hit) begin
            map_we    = 1'b1;
            map_waddr = r_nb_pos;
            map_wdata = MAP_SEEN;
            stk_we    = 1'b1;
            stk_waddr = AW'(r_sp);
            stk_wdata = {r_nb_r, r_nb_c, r_nb_pos};
        end
        if (i_cmd.nb && q_ok) begin
            map_re    = 1'b1;
            map_raddr = q_pos;
        end
    end

    // Control counters and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= RCW'(mia_pkg::clamp_dim(mia_pkg::CFG_W'(mia_pkg::ROW_RESET), MAX_ROWS));
            r_cols      <= CCW'(mia_pkg::clamp_dim(mia_pkg::CFG_W'(mia_pkg::COL_RESET), MAX_COLS));
            r_clr_idx   <= '0;
            r_load_idx  <= '0;
            r_scan_idx  <= '0;
            r_chk_v     <= 1'b0;
            r_sp        <= '0;
            r_area      <= '0;
            r_best      <= '0;
            r_dir       <= DIR_UP;
            r_nb_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mia_pkg::REG_ROW_COUNT: begin
                        r_rows <= RCW'(mia_pkg::clamp_dim(i_cfg_data, MAX_ROWS));
                    end
                    mia_pkg::REG_COL_COUNT: begin
                        r_cols <= CCW'(mia_pkg::clamp_dim(i_cfg_data, MAX_COLS));
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.load && load_ok) begin
                r_load_idx <= r_load_idx + TW'(1);
            end
            if (i_cmd.scan_init) begin
                r_scan_idx <= '0;
                r_chk_v    <= 1'b0;
                r_best     <= '0;
            end
            if (i_cmd.scan) begin
                if (scan_hit) begin
                    // No map read is issued in this cycle; the scan resumes from r_scan_idx after the fill.
                    r_chk_v <= 1'b0;
                    r_sp    <= TW'(1);
                    r_area  <= '0;
                end else if (scan_more) begin
                    r_chk_v    <= 1'b1;
                    r_scan_idx <= r_scan_idx + TW'(1);
                end else begin
                    r_chk_v <= 1'b0;
                end
            end
            if (i_cmd.pop) begin
                r_sp   <= r_sp - TW'(1);
                r_area <= r_area + TW'(1);
                r_dir  <= DIR_UP;
                r_nb_v <= 1'b0;
            end
            if (i_cmd.nb) begin
                r_nb_v <= q_ok;
                r_dir  <= r_dir + 2'd1;
            end
            if (i_cmd.nb_chk) begin
                r_nb_v <= 1'b0;
            end
            if ((i_cmd.nb || i_cmd.nb_chk) && nb_hit) begin
                r_sp <= r_sp + TW'(1);
            end
            if (i_cmd.region_end && (r_area > r_best)) begin
                r_best <= r_area;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_clr_idx   <= '0;
                r_load_idx  <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_r <= '0;
            r_scan_c <= '0;
        end
        if (i_cmd.scan && !scan_hit && scan_more) begin
            r_chk_pos <= AW'(r_scan_idx);
            r_chk_r   <= r_scan_r;
            r_chk_c   <= r_scan_c;
            if (scan_wrap) begin
                r_scan_c <= '0;
                r_scan_r <= r_scan_r + RW'(1);
            end else begin
                r_scan_c <= r_scan_c + CW'(1);
            end
        end
        if (i_cmd.nb) begin
            r_nb_pos <= q_pos;
            r_nb_r   <= q_r;
            r_nb_c   <= q_c;
        end
        if (i_cmd.emit) begin
            if (int'(r_best) > mia_pkg::AREA_MAX) begin
                r_out_area <= mia_pkg::AREA_W'(mia_pkg::AREA_MAX);
            end else begin
                r_out_area <= mia_pkg::AREA_W'(r_best);
            end
        end
    end

    mia_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    mia_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_stat.clr_done  = r_clr_idx == AW'(CELLS - 1);
    assign o_stat.scan_hit  = scan_hit;
    assign o_stat.scan_done = !r_chk_v && !scan_more;
    assign o_stat.sp_zero   = r_sp == '0;
    assign o_stat.dir_last  = r_dir == DIR_DOWN;
    assign o_stat.out_busy  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_max_area  = r_out_area;

endmodule

// ===== design/max_island_area_core.sv =====
`timescale 1ns / 1ps
// Top level of the max island area block: controller plus datapath.
// Depends on mia_pkg, mia_ctrl, mia_dp (and mia_ram through the datapath).
//
// Usage: a binary image streams in on the s_axis channel, one pixel per request in
// row-major order, pixel in tdata bit 0, tlast on the final pixel of the frame.
// Image size comes from the row_count (index 0) and col_count (index 1) registers,
// written through i_cfg_we/i_cfg_idx/i_cfg_data between frames.
// After tlast the block scans the stored image and flood-fills every 4-connected
// region, then presents one result on m_axis: the area of the largest region
// (0 when no pixel is set), saturated to 13 bits.
// The scan reads the pixel/visited map at one pixel per cycle, pausing while a region is
// flood-filled; each set pixel then goes through one stack pop, four neighbor map reads
// through the single map read port, and a final check, and each region ends with a pop
// that finds the stack empty. After the result is registered, a clearing pass over all
// MAX_ROWS*MAX_COLS map entries wipes the map before the next frame is taken.
// The same clearing pass runs after reset, with s_axis_tready low throughout.
// If the receiver stalls, the result holds on m_axis; the next frame still loads,
// but its result waits until the previous one has been taken.

module max_island_area_core #(
    parameter int MAX_ROWS = mia_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mia_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mia_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // [0] pixel, rest zero
    input  logic                                s_axis_tlast,   // last_pixel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mia_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [12:0] max_area, rest zero
    input  logic                                i_cfg_we,
    input  logic [mia_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mia_pkg::CFG_W-1:0]           i_cfg_data
);

    mia_pkg::t_cmd  cmd;
    mia_pkg::t_stat stat;
    logic [mia_pkg::AREA_W-1:0] max_area;

    mia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mia_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_pixel     (s_axis_tdata[0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_max_area  (max_area)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {{(mia_pkg::OUT_DATA_W - mia_pkg::AREA_W){1'b0}}, max_area};

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for max_island_area_core: a directed table followed by random frames.
// Results are checked against the table area or a flood-fill predictor. Depends on mia_pkg and the core RTL.

module tb_top;

    localparam int CELLS         = mia_pkg::MAX_ROWS_DEF * mia_pkg::MAX_COLS_DEF;
    // The core clears all CELLS map entries after each result.
    localparam int SETTLE_CYCLES = CELLS + 64;
    localparam int RAND_ITEMS    = 1900;
    localparam int HOLD_CYCLES   = 16000;
    localparam int GAP_PCT       = 13;
    localparam int TIMEOUT_NS    = 20_000_000;

    typedef enum logic {DIR_WRITE, DIR_PIXEL} t_dir_kind;

    // For a write row, value is the register data. For a pixel row, value[0] is the pixel.
    typedef struct packed {
        t_dir_kind                      kind;
        logic [mia_pkg::CFG_IDX_W-1:0]  idx;
        logic [mia_pkg::CFG_W-1:0]      value;
        logic                           last;
        logic                           typed;
        logic [mia_pkg::AREA_W-1:0]     area;
    } t_dir_row;

    localparam int DIR_ROWS = 35;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Size after reset is 64 x 64; single-pixel short frames.
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b1, 13'd1},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b1, 1'b1, 13'd0},
        // A zero row count acts as one row.
        '{DIR_WRITE, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_WRITE, mia_pkg::REG_COL_COUNT, 7'd3,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b1, 13'd3},
        // Long frame: the fourth pixel falls past the image and is dropped.
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b1, 13'd1},
        // Diagonal neighbors are not connected.
        '{DIR_WRITE, mia_pkg::REG_ROW_COUNT, 7'd2,   1'b0, 1'b0, 13'd0},
        '{DIR_WRITE, mia_pkg::REG_COL_COUNT, 7'd2,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b1, 13'd1},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b1, 13'd3},
        // Oversized row count saturates and a zero column count acts as one.
        '{DIR_WRITE, mia_pkg::REG_ROW_COUNT, 7'd127, 1'b0, 1'b0, 13'd0},
        '{DIR_WRITE, mia_pkg::REG_COL_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd0,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b1, 13'd2},
        // The image shrinks while a frame is half loaded.
        '{DIR_WRITE, mia_pkg::REG_ROW_COUNT, 7'd2,   1'b0, 1'b0, 13'd0},
        '{DIR_WRITE, mia_pkg::REG_COL_COUNT, 7'd3,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_WRITE, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b0, 1'b0, 13'd0},
        '{DIR_PIXEL, mia_pkg::REG_ROW_COUNT, 7'd1,   1'b1, 1'b0, 13'd0}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [mia_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;   // [0] pixel
    logic                               s_axis_tlast = 1'b0; // last_pixel
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [mia_pkg::OUT_DATA_W-1:0]     m_axis_tdata;        // [12:0] max_area
    logic                               i_cfg_we = 1'b0;
    logic [mia_pkg::CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [mia_pkg::CFG_W-1:0]          i_cfg_data = '0;

    // Predictor state.
    logic [mia_pkg::CFG_W-1:0]          rows_cfg = mia_pkg::CFG_W'(mia_pkg::ROW_RESET);
    logic [mia_pkg::CFG_W-1:0]          cols_cfg = mia_pkg::CFG_W'(mia_pkg::COL_RESET);
    bit                                 pix_map [CELLS];
    int                                 load_pos = 0;
    logic [mia_pkg::AREA_W-1:0]         area_q [$];

    int                                 errors = 0;
    int                                 item_count = 0;
    bit                                 hold_req = 1'b0;
    bit                                 gaps_on = 1'b1;
    bit                                 since_idle = 1'b0;

    max_island_area_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int dim_in_use(input logic [mia_pkg::CFG_W-1:0] v, input int lim);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > lim) begin
            return lim;
        end
        return int'(v);
    endfunction

    function automatic int image_cells();
        return dim_in_use(rows_cfg, mia_pkg::MAX_ROWS_DEF)
             * dim_in_use(cols_cfg, mia_pkg::MAX_COLS_DEF);
    endfunction

    // Area of the largest 4-connected region of set pixels in the current image.
    function automatic logic [mia_pkg::AREA_W-1:0] largest_region();
        bit seen [CELLS];
        int pend [CELLS];
        int rows, cols, sp, region, best, pos, r, c, nr, nc, q, i, d;
        rows = dim_in_use(rows_cfg, mia_pkg::MAX_ROWS_DEF);
        cols = dim_in_use(cols_cfg, mia_pkg::MAX_COLS_DEF);
        for (i = 0; i < CELLS; i++) begin
            seen[i] = 1'b0;
        end
        best = 0;
        for (i = 0; i < rows * cols; i++) begin
            if (pix_map[i] && !seen[i]) begin
                seen[i] = 1'b1;
                pend[0] = i;
                sp = 1;
                region = 0;
                while (sp > 0) begin
                    sp--;
                    pos = pend[sp];
                    region++;
                    r = pos / cols;
                    c = pos % cols;
                    // Neighbors up, left, right and down.
                    for (d = 0; d < 4; d++) begin
                        nr = r;
                        nc = c;
                        case (d)
                            0: nr = r - 1;
                            1: nc = c - 1;
                            2: nc = c + 1;
                            default: nr = r + 1;
                        endcase
                        if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                            q = nr * cols + nc;
                            if (pix_map[q] && !seen[q]) begin
                                seen[q] = 1'b1;
                                pend[sp] = q;
                                sp++;
                            end
                        end
                    end
                end
                if (region > best) begin
                    best = region;
                end
            end
        end
        return (best > mia_pkg::AREA_MAX) ? mia_pkg::AREA_W'(mia_pkg::AREA_MAX)
                                          : mia_pkg::AREA_W'(best);
    endfunction

    task automatic clear_image();
        int k;
        for (k = 0; k < CELLS; k++) begin
            pix_map[k] = 1'b0;
        end
        load_pos = 0;
    endtask

    // Drops valid, then waits for every pending result and for the clearing pass.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (area_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        since_idle = 1'b0;
    endtask

    task automatic write_reg(input logic [mia_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mia_pkg::CFG_W-1:0] val);
        if (since_idle) begin
            wait_idle();
        end
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == mia_pkg::REG_ROW_COUNT) begin
            rows_cfg = val;
        end else begin
            cols_cfg = val;
        end
    endtask

    // Sends one pixel request and updates the predictor once it is accepted.
    task automatic push_pixel(input logic px, input logic lst, input logic typed,
                              input logic [mia_pkg::AREA_W-1:0] typed_area);
        logic [mia_pkg::AREA_W-1:0] area;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(mia_pkg::IN_DATA_W-1){1'b0}}, px};
        s_axis_tlast  = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        since_idle = 1'b1;
        if (load_pos < image_cells()) begin
            pix_map[load_pos] = px;
            load_pos++;
            item_count++;
        end else if (lst) begin
            item_count++;
        end
        if (lst) begin
            area = largest_region();
            area_q.push_back(typed ? typed_area : area);
            clear_image();
        end
    endtask

    task automatic pick_size();
        logic [mia_pkg::CFG_W-1:0] r, c;
        case ($urandom_range(0, 19))
            0: begin
                r = 7'd64;
                c = 7'd64;
            end
            1: begin
                r = 7'd1;
                c = 7'd64;
            end
            2: begin
                r = 7'd64;
                c = 7'd1;
            end
            3: begin
                r = mia_pkg::CFG_W'($urandom_range(0, 127));
                c = mia_pkg::CFG_W'($urandom_range(0, 127));
            end
            default: begin
                r = mia_pkg::CFG_W'($urandom_range(1, 8));
                c = mia_pkg::CFG_W'($urandom_range(1, 8));
            end
        endcase
        write_reg(mia_pkg::REG_ROW_COUNT, r);
        write_reg(mia_pkg::REG_COL_COUNT, c);
    endtask

    task automatic send_random_frame();
        int total, len, density, split, k;
        logic px;
        total = image_cells();
        // Large images only get frames of at most 300 pixels to keep the run time down.
        if (total > 256) begin
            len = $urandom_range(1, 300);
        end else begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, total);
                1: len = total + $urandom_range(1, 6);
                default: len = total;
            endcase
        end
        case ($urandom_range(0, 9))
            0: density = 0;
            1: density = 100;
            default: density = $urandom_range(5, 95);
        endcase
        split = 0;
        if (total <= 256 && len > 1 && $urandom_range(0, 7) == 0) begin
            split = $urandom_range(1, len - 1);
        end
        for (k = 0; k < len; k++) begin
            if (split != 0 && k == split) begin
                write_reg($urandom_range(0, 1) ? mia_pkg::REG_COL_COUNT
                                               : mia_pkg::REG_ROW_COUNT,
                          mia_pkg::CFG_W'($urandom_range(1, 8)));
            end
            px = ($urandom_range(0, 99) < density);
            push_pixel(px, k == len - 1, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int i, n_frames, phase;
        t_dir_row row;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == DIR_WRITE) begin
                write_reg(row.idx, row.value);
            end else begin
                push_pixel(row.value[0], row.last, row.typed, row.area);
            end
        end
        wait_idle();
        item_count = 0;
        phase = 0;
        while (item_count < RAND_ITEMS) begin
            gaps_on = (phase != 1) && ($urandom_range(0, 4) != 0);
            pick_size();
            n_frames = $urandom_range(1, 5);
            // Hold the result side long enough that the core backs up into its input.
            if (phase == 3) begin
                hold_req = 1'b1;
                n_frames = 5;
            end
            repeat (n_frames) send_random_frame();
            wait_idle();
            phase++;
        end
        if (errors == 0) begin
            $display("max_island_area_core test passed");
        end else begin
            $display("max_island_area_core test failed");
        end
        $finish;
    end

    initial begin : result_sink
        int rx_hold_left;
        bit hold_taken;
        rx_hold_left = 0;
        hold_taken   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken   = 1'b1;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                m_axis_tready = 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready = !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [mia_pkg::AREA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (area_q.size() == 0) begin
                $error("max_area: unexpected result, actual %0d",
                       m_axis_tdata[mia_pkg::AREA_W-1:0]);
                errors++;
            end else begin
                want = area_q.pop_front();
                if (m_axis_tdata[mia_pkg::AREA_W-1:0] !== want) begin
                    $error("max_area mismatch: expected %0d, actual %0d",
                           want, m_axis_tdata[mia_pkg::AREA_W-1:0]);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("max_island_area_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mia_pkg.sv
design/mia_ram.sv
design/mia_ctrl.sv
design/mia_dp.sv
design/max_island_area_core.sv
dv/tb_top.sv
